@@ design/ssem_pkg.sv @@
// Shared types and constants for the SSEM instruction-step block.
`timescale 1ns / 1ps

package ssem_pkg;

    localparam int STORE_LINES_DEF = 32;
    localparam int WORD_W          = 32;
    localparam int LINE_W          = 5;
    localparam int OPC_W           = 3;
    localparam int OPC_LSB         = 13;
    localparam int OPC_MSB         = 15;
    localparam int OPND_MSB        = 4;
    localparam int SIGN_BIT        = 31;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 72;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef enum logic [OPC_W-1:0] {
        OP_JMP  = 3'd0,
        OP_JRP  = 3'd1,
        OP_LDN  = 3'd2,
        OP_STO  = 3'd3,
        OP_SUB  = 3'd4,
        OP_SUBA = 3'd5,
        OP_CMP  = 3'd6,
        OP_STOP = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_OPER = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [LINE_W-1:0] rd_addr;
        logic              wr_en;
        logic [LINE_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
    } store_req_t;

endpackage

@@ design/ssem_store.sv @@
// Main store: synchronous memory with per-line valid bits cleared at reset.
`timescale 1ns / 1ps

module ssem_store #(
    parameter int STORE_LINES = ssem_pkg::STORE_LINES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ssem_pkg::store_req_t      req,
    output logic [ssem_pkg::WORD_W-1:0] rd_data
);
    import ssem_pkg::*;

    localparam int ADDR_W = $clog2(STORE_LINES);

    logic [WORD_W-1:0]      mem [STORE_LINES];
    logic [STORE_LINES-1:0] valid_reg;
    logic [WORD_W-1:0]      rd_word_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr[ADDR_W-1:0]] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_word_reg  <= mem[req.rd_addr[ADDR_W-1:0]];
            rd_valid_reg <= valid_reg[req.rd_addr[ADDR_W-1:0]];
        end
    end

    // Lines never written read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr[ADDR_W-1:0]] <= 1'b1;
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

@@ design/ssem_core.sv @@
// Instruction sequencer: registers, fetch/operand/execute steps and result beat.
`timescale 1ns / 1ps

module ssem_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    input  logic                          item_action,
    input  logic [ssem_pkg::LINE_W-1:0]   item_index,
    input  logic [ssem_pkg::WORD_W-1:0]   item_value,
    output logic                          item_take,
    output ssem_pkg::store_req_t          st_req,
    input  logic [ssem_pkg::WORD_W-1:0]   st_rdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // fields from bit 0: halted, acc_value, counter_value, executed_opcode, zero pad
    output logic [ssem_pkg::M_DATA_W-1:0] m_tdata
);
    import ssem_pkg::*;

    state_t            state_reg, state_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] pc_reg, pc_next;
    logic              skip_reg, skip_next;
    logic              stop_reg, stop_next;
    opcode_t           op_reg, op_next;

    logic              m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic              out_free;
    logic              finish;
    logic [OPC_W-1:0]  fin_opc;
    opcode_t           word_op;

    assign out_free = !m_valid_reg || m_tready;
    assign word_op  = opcode_t'(st_rdata[OPC_MSB:OPC_LSB]);

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        pc_next    = pc_reg;
        skip_next  = skip_reg;
        stop_next  = stop_reg;
        op_next    = op_reg;
        item_take  = 1'b0;
        finish     = 1'b0;
        fin_opc    = '0;
        st_req     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid && out_free) begin
                    item_take = 1'b1;
                    if (item_action == ACT_LOAD) begin
                        st_req.wr_en   = 1'b1;
                        st_req.wr_addr = item_index;
                        st_req.wr_data = item_value;
                        finish         = 1'b1;
                    end else if (stop_reg) begin
                        finish = 1'b1;
                    end else begin
                        // advance the counter and fetch the instruction line
                        pc_next        = pc_reg + (skip_reg ? WORD_W'(2) : WORD_W'(1));
                        skip_next      = 1'b0;
                        st_req.rd_en   = 1'b1;
                        st_req.rd_addr = pc_next[LINE_W-1:0];
                        state_next     = ST_OPER;
                    end
                end
            end
            ST_OPER: begin
                op_next = word_op;
                fin_opc = word_op;
                case (word_op)
                    OP_STO: begin
                        st_req.wr_en   = 1'b1;
                        st_req.wr_addr = st_rdata[OPND_MSB:0];
                        st_req.wr_data = acc_reg;
                        finish         = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    OP_CMP: begin
                        if (acc_reg[SIGN_BIT]) begin
                            skip_next = 1'b1;
                        end
                        finish     = 1'b1;
                        state_next = ST_IDLE;
                    end
                    OP_STOP: begin
                        stop_next  = 1'b1;
                        finish     = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default: begin
                        st_req.rd_en   = 1'b1;
                        st_req.rd_addr = st_rdata[OPND_MSB:0];
                        state_next     = ST_EXEC;
                    end
                endcase
            end
            ST_EXEC: begin
                fin_opc = op_reg;
                case (op_reg) inside
                    OP_JMP:           pc_next  = st_rdata;
                    OP_JRP:           pc_next  = pc_reg + st_rdata;
                    OP_LDN:           acc_next = '0 - st_rdata;
                    OP_SUB, OP_SUBA:  acc_next = acc_reg - st_rdata;
                    default:          acc_next = acc_reg;
                endcase
                finish     = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            pc_reg      <= '0;
            skip_reg    <= 1'b0;
            stop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            pc_reg    <= pc_next;
            skip_reg  <= skip_next;
            stop_reg  <= stop_next;
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next;
        if (finish) begin
            m_data_reg <= {{(M_DATA_W - 1 - 2*WORD_W - OPC_W){1'b0}},
                           fin_opc, pc_next, acc_next, stop_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ design/ssem_instruction_step.sv @@
// Top level of the SSEM instruction-step block: input beat buffer, sequencer, store.
`timescale 1ns / 1ps

// Usage
//   Slave channel (s_*): one beat per item. s_tuser carries the action
//   (0 = write a store line, 1 = execute one instruction step); s_tdata
//   carries the line index and the line value for load beats.
//   Master channel (m_*): exactly one result beat per input beat, in order,
//   carrying the stop flag, accumulator, instruction counter and the opcode
//   just executed (zero for loads and for steps taken while stopped).
//   A load, or a step while stopped, completes from the idle state; STO,
//   CMP and STOP complete in the operand step; JMP, JRP, LDN and SUB also
//   need the execute step. The single store port sets this: one access
//   for the instruction line, one for the operand line or its write-back.
//   Each beat is registered in the input buffer before the sequencer.
//   A one-beat input buffer takes the next item while the sequencer works,
//   and a result register holds a finished result while the receiver stalls;
//   a new item starts only once that register can take its result.
//   Reset (aresetn low, synchronous) clears the accumulator, counter and
//   both flags, empties both beats, and marks every store line unwritten so
//   that it reads as zero; no clearing pass is needed.
module ssem_instruction_step #(
    parameter int STORE_LINES = ssem_pkg::STORE_LINES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // fields from bit 0: line_index[4:0], line_value[36:5], zero pad
    input  logic [ssem_pkg::S_DATA_W-1:0] s_tdata,
    // fields from bit 0: action
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // fields from bit 0: halted, acc_value[32:1], counter_value[64:33],
    // executed_opcode[67:65], zero pad
    output logic [ssem_pkg::M_DATA_W-1:0] m_tdata
);
    import ssem_pkg::*;

    // input beat buffer
    logic              buf_valid_reg;
    logic              buf_action_reg;
    logic [LINE_W-1:0] buf_index_reg;
    logic [WORD_W-1:0] buf_value_reg;

    logic              item_take;
    store_req_t        st_req;
    logic [WORD_W-1:0] st_rdata;

    // Accept a new beat whenever the buffer is empty or drains this cycle.
    assign s_tready = !buf_valid_reg || item_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            buf_valid_reg <= 1'b1;
        end else if (item_take) begin
            buf_valid_reg <= 1'b0;
        end
    end

    // Hold the payload until the sequencer takes it.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            buf_action_reg <= s_tuser[0];
            buf_index_reg  <= s_tdata[LINE_W-1:0];
            buf_value_reg  <= s_tdata[LINE_W+WORD_W-1:LINE_W];
        end
    end

    ssem_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (buf_valid_reg),
        .item_action (buf_action_reg),
        .item_index  (buf_index_reg),
        .item_value  (buf_value_reg),
        .item_take   (item_take),
        .st_req      (st_req),
        .st_rdata    (st_rdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    ssem_store #(
        .STORE_LINES (STORE_LINES)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (st_req),
        .rd_data (st_rdata)
    );

endmodule
